>>> rtl/sprite_quad_batcher_defines.svh
// ----------------------------------------------------------------------------
// Sprite quad batcher assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_BATCHER_DEFINES_SVH
`define SPRITE_QUAD_BATCHER_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define SQB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define SQB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sqb_pkg.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher package
// Shared widths, command codes, corner tables and the queued quad type.
// ----------------------------------------------------------------------------
`default_nettype none

package sqb_pkg;

    localparam int MAX_TEXTURES_DEF = 16;
    localparam int COORD_W          = 16;
    localparam int SIZE_W           = 15;
    localparam int HALF_W           = SIZE_W - 1;
    localparam int HANDLE_W         = 32;
    localparam int COLOUR_W         = 32;
    localparam int SLOT_W           = 5;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CORNERS          = 4;
    localparam int CORNER_W         = 2;

    // Command codes.
    localparam logic CMD_BEGIN  = 1'b0;
    localparam logic CMD_SUBMIT = 1'b1;

    // Per-corner tables, bit k belongs to corner k.
    localparam logic [CORNERS-1:0] CORNER_U    = 4'b0110;
    localparam logic [CORNERS-1:0] CORNER_V    = 4'b1100;
    localparam logic [CORNERS-1:0] CORNER_XNEG = 4'b1001;
    localparam logic [CORNERS-1:0] CORNER_YNEG = 4'b1100;

    // One classified sprite waiting for expansion.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [HALF_W-1:0]         hw;
        logic [HALF_W-1:0]         hh;
        logic [SLOT_W-1:0]         slot;
        logic [COLOUR_W-1:0]       colour;
        logic                      flush;
    } quad_t;

    // Centre plus or minus a half size, saturated to the coordinate range.
    function automatic logic [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] centre,
        input logic [HALF_W-1:0]         half,
        input logic                      neg
    );
        logic signed [COORD_W:0] c_ext;
        logic signed [COORD_W:0] h_ext;
        logic signed [COORD_W:0] sum;
        logic [COORD_W-1:0]      res;
        c_ext = {centre[COORD_W-1], centre};
        h_ext = {{(COORD_W + 1 - HALF_W){1'b0}}, half};
        sum   = neg ? (c_ext - h_ext) : (c_ext + h_ext);
        if (sum[COORD_W] != sum[COORD_W-1]) begin
            res = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else begin
            res = sum[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sqb_front.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher front end
// Accepts requests, keeps the bound-texture table and resolves each sprite's
// texture slot before handing it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sqb_front #(
    parameter int MAX_TEXTURES = sqb_pkg::MAX_TEXTURES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic signed [sqb_pkg::COORD_W-1:0] centre_x,
    input  wire logic signed [sqb_pkg::COORD_W-1:0] centre_y,
    input  wire logic [sqb_pkg::SIZE_W-1:0]         width,
    input  wire logic [sqb_pkg::SIZE_W-1:0]         height,
    input  wire logic                               has_texture,
    input  wire logic [sqb_pkg::HANDLE_W-1:0]       texture_handle,
    input  wire logic [sqb_pkg::COLOUR_W-1:0]       colour,
    output logic                                    push_valid,
    input  wire logic                               push_ready,
    output sqb_pkg::quad_t                          push_data
);

    localparam int IDX_W = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
    localparam int CNT_W = $clog2(MAX_TEXTURES + 1);

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_CMP  = 3'b010,
        FS_RES  = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;

    // Captured request.
    logic signed [sqb_pkg::COORD_W-1:0] cx_reg, cy_reg;
    logic [sqb_pkg::HALF_W-1:0]         hw_reg, hh_reg;
    logic                               tex_reg;
    logic [sqb_pkg::HANDLE_W-1:0]       handle_reg;
    logic [sqb_pkg::COLOUR_W-1:0]       colour_reg;

    // Bound-texture table and its registered compare result.
    logic [sqb_pkg::HANDLE_W-1:0] tab_reg [MAX_TEXTURES];
    logic [MAX_TEXTURES-1:0]      match_reg, match_next;

    logic                  accept;
    logic                  hit_found;
    logic [IDX_W-1:0]      hit_idx;
    logic                  full;
    logic [IDX_W-1:0]      wr_idx;
    logic [CNT_W-1:0]      miss_used;
    logic [CNT_W-1:0]      slot_cnt;
    logic [CNT_W+4:0]      slot_ext;
    logic                  flush;
    logic                  tab_write;

    assign in_stall = (state_reg != FS_IDLE);
    assign accept   = in_valid && !in_stall;

    // Compare every valid entry against the captured handle.
    always_comb
    begin
        for (int i = 0; i < MAX_TEXTURES; i++)
        begin
            match_next[i] = (CNT_W'(i) < used_reg) && (tab_reg[i] == handle_reg);
        end
    end

    // Lowest matching entry wins.
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = MAX_TEXTURES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
        end
    end

    // Slot resolution: slot zero when untextured, hit, append, or clear a full table and append.
    always_comb
    begin
        full      = (used_reg == CNT_W'(MAX_TEXTURES));
        wr_idx    = full ? '0 : used_reg[IDX_W-1:0];
        miss_used = full ? CNT_W'(1) : (used_reg + CNT_W'(1));
        flush     = 1'b0;
        tab_write = 1'b0;
        if (!tex_reg)
        begin
            slot_cnt = '0;
        end
        else if (hit_found)
        begin
            slot_cnt = CNT_W'(hit_idx) + CNT_W'(1);
        end
        else
        begin
            slot_cnt  = miss_used;
            flush     = full;
            tab_write = 1'b1;
        end
        slot_ext = (CNT_W + 5)'(slot_cnt);
    end

    assign push_valid       = (state_reg == FS_RES);
    assign push_data.cx     = cx_reg;
    assign push_data.cy     = cy_reg;
    assign push_data.hw     = hw_reg;
    assign push_data.hh     = hh_reg;
    assign push_data.slot   = slot_ext[sqb_pkg::SLOT_W-1:0];
    assign push_data.colour = colour_reg;
    assign push_data.flush  = flush;

    // Sequencing and table fill count.
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (accept)
                begin
                    if (command == sqb_pkg::CMD_BEGIN)
                    begin
                        used_next = '0;
                    end
                    else
                    begin
                        state_next = FS_CMP;
                    end
                end
            end
            FS_CMP:
            begin
                state_next = FS_RES;
            end
            FS_RES:
            begin
                if (push_ready)
                begin
                    state_next = FS_IDLE;
                    if (tab_write)
                    begin
                        used_next = miss_used;
                    end
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
        end
    end

    // Request capture and compare result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg     <= centre_x;
            cy_reg     <= centre_y;
            hw_reg     <= width[sqb_pkg::SIZE_W-1:1];
            hh_reg     <= height[sqb_pkg::SIZE_W-1:1];
            tex_reg    <= has_texture;
            handle_reg <= texture_handle;
            colour_reg <= colour;
        end
        if (state_reg == FS_CMP)
        begin
            match_reg <= match_next;
        end
    end

    // Table write on an appended handle.
    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready && tab_write)
        begin
            tab_reg[wr_idx] <= handle_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sqb_queue.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher queue
// Short FIFO of resolved sprites between the front end and the expander.
// ----------------------------------------------------------------------------
`default_nettype none

module sqb_queue #(
    parameter int DEPTH = sqb_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire sqb_pkg::quad_t  push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output sqb_pkg::quad_t       pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sqb_pkg::quad_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sqb_back.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher back end
// Expands one queued sprite into four corner vertices, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sqb_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire sqb_pkg::quad_t               pop_data,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [sqb_pkg::COORD_W-1:0]       vertex_x,
    output logic [sqb_pkg::COORD_W-1:0]       vertex_y,
    output logic                              tex_u,
    output logic                              tex_v,
    output logic [sqb_pkg::SLOT_W-1:0]        slot,
    output logic [sqb_pkg::COLOUR_W-1:0]      vertex_colour,
    output logic                              flush_before,
    output logic                              last
);

    sqb_pkg::quad_t                 ent_reg;
    logic                           busy_reg, busy_next;
    logic [sqb_pkg::CORNER_W-1:0]   corner_reg, corner_next;
    logic                           out_valid_reg, out_valid_next;

    logic [sqb_pkg::COORD_W-1:0]    vx_reg, vy_reg;
    logic                           u_reg, v_reg, flush_reg, last_reg;
    logic [sqb_pkg::SLOT_W-1:0]     slot_reg;
    logic [sqb_pkg::COLOUR_W-1:0]   colour_reg;

    logic advance;
    logic last_corner;
    logic do_pop;

    assign advance     = busy_reg && (!out_valid_reg || !out_stall);
    assign last_corner = (corner_reg == sqb_pkg::CORNER_W'(sqb_pkg::CORNERS - 1));
    assign pop_ready   = !busy_reg || (advance && last_corner);
    assign do_pop      = pop_valid && pop_ready;

    // Corner sequencing and output valid.
    always_comb
    begin
        busy_next      = busy_reg;
        corner_next    = corner_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            corner_next    = corner_reg + sqb_pkg::CORNER_W'(1);
            if (last_corner)
            begin
                busy_next = 1'b0;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (do_pop)
        begin
            busy_next   = 1'b1;
            corner_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sprite capture and corner computation.
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            ent_reg <= pop_data;
        end
        if (advance)
        begin
            vx_reg     <= sqb_pkg::sat_add(ent_reg.cx, ent_reg.hw,
                                           sqb_pkg::CORNER_XNEG[corner_reg]);
            vy_reg     <= sqb_pkg::sat_add(ent_reg.cy, ent_reg.hh,
                                           sqb_pkg::CORNER_YNEG[corner_reg]);
            u_reg      <= sqb_pkg::CORNER_U[corner_reg];
            v_reg      <= sqb_pkg::CORNER_V[corner_reg];
            slot_reg   <= ent_reg.slot;
            colour_reg <= ent_reg.colour;
            flush_reg  <= ent_reg.flush && (corner_reg == '0);
            last_reg   <= last_corner;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex_x      = vx_reg;
    assign vertex_y      = vy_reg;
    assign tex_u         = u_reg;
    assign tex_v         = v_reg;
    assign slot          = slot_reg;
    assign vertex_colour = colour_reg;
    assign flush_before  = flush_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

>>> rtl/sprite_quad_batcher.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher
// Expands sprite requests into four saturated corner vertices and assigns
// texture slots from a per-batch table of bound textures.
// ----------------------------------------------------------------------------
// A begin-frame request only resets the texture table. A submit request
// occupies the front end through capture, a parallel compare against all
// bound handles and slot resolution before it enters a two-entry queue;
// the back end then issues one corner per cycle while the output is not
// stalled, and the single output port sets the sustained sprite rate. With
// no stall, a request passes the capture registers, the compare result
// register, the queue, the back end's sprite register and its output
// registers before its first corner is presented. Corners come in the order
// (-w,+h), (+w,+h), (+w,-h), (-w,-h) about the centre, using half sizes.
`default_nettype none

module sprite_quad_batcher #(
    parameter int MAX_TEXTURES = sqb_pkg::MAX_TEXTURES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic signed [sqb_pkg::COORD_W-1:0] centre_x,
    input  wire logic signed [sqb_pkg::COORD_W-1:0] centre_y,
    input  wire logic [sqb_pkg::SIZE_W-1:0]         width,
    input  wire logic [sqb_pkg::SIZE_W-1:0]         height,
    input  wire logic                               has_texture,
    input  wire logic [sqb_pkg::HANDLE_W-1:0]       texture_handle,
    input  wire logic [sqb_pkg::COLOUR_W-1:0]       colour,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [sqb_pkg::COORD_W-1:0]      vertex_x,
    output logic signed [sqb_pkg::COORD_W-1:0]      vertex_y,
    output logic                                    tex_u,
    output logic                                    tex_v,
    output logic [sqb_pkg::SLOT_W-1:0]              slot,
    output logic [sqb_pkg::COLOUR_W-1:0]            vertex_colour,
    output logic                                    flush_before,
    output logic                                    last
);

    logic           push_valid, push_ready;
    logic           pop_valid, pop_ready;
    sqb_pkg::quad_t push_data, pop_data;
    logic [sqb_pkg::COORD_W-1:0] vx, vy;

    // Request decode and texture slot resolution.
    sqb_front #(
        .MAX_TEXTURES (MAX_TEXTURES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .centre_x       (centre_x),
        .centre_y       (centre_y),
        .width          (width),
        .height         (height),
        .has_texture    (has_texture),
        .texture_handle (texture_handle),
        .colour         (colour),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    // Decoupling queue.
    sqb_queue #(
        .DEPTH (sqb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Corner expansion.
    sqb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_x      (vx),
        .vertex_y      (vy),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .slot          (slot),
        .vertex_colour (vertex_colour),
        .flush_before  (flush_before),
        .last          (last)
    );

    assign vertex_x = $signed(vx);
    assign vertex_y = $signed(vy);

endmodule

`default_nettype wire

>>> rtl/sqb_checker.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher checker
// Port-level assertions on request sequencing and corner ordering.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_quad_batcher_defines.svh"

module sqb_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_stall,
    input wire logic                         command,
    input wire logic                         out_valid,
    input wire logic                         out_stall,
    input wire logic [sqb_pkg::COORD_W-1:0]  vertex_x,
    input wire logic [sqb_pkg::COORD_W-1:0]  vertex_y,
    input wire logic                         tex_u,
    input wire logic                         tex_v,
    input wire logic [sqb_pkg::SLOT_W-1:0]   slot,
    input wire logic [sqb_pkg::COLOUR_W-1:0] vertex_colour,
    input wire logic                         flush_before,
    input wire logic                         last
);

    // A stalled result holds its payload.
    `SQB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(vertex_x) && $stable(vertex_y) && $stable(slot) && $stable(vertex_colour) && $stable(last), "stalled result changed")

    // An accepted submit keeps the front end busy for the lookup.
    `SQB_ASSERT_NEXT(a_submit_busy, in_valid && !in_stall && (command == sqb_pkg::CMD_SUBMIT), in_stall, "submit did not occupy the front end")

    // A flush marks the first corner and always lands in the first slot.
    `SQB_ASSERT_NOW(a_flush_corner, out_valid && flush_before, !tex_u && !tex_v && !last && (slot == 5'd1), "flush on wrong corner or slot")

    // The closing corner carries the last texture coordinates.
    `SQB_ASSERT_NOW(a_last_corner, out_valid && last, !tex_u && tex_v && !flush_before, "last flag on wrong corner")

endmodule

bind sprite_quad_batcher sqb_checker u_sqb_checker (.*);

`default_nettype wire

>>> tb/tb_sprite_quad_batcher.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher testbench
// Sends begin-frame and sprite requests and predicts the four corners of each
// sprite, including texture slot lookup, table flush and coordinate
// saturation. Every corner that leaves the block is checked field by field,
// with random idling on both sides, a long output hold-off and a final
// stretch with no idling.
// ----------------------------------------------------------------------------
module tb_sprite_quad_batcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES     = 20;

    typedef logic signed [sqb_pkg::COORD_W-1:0] coord_t;
    typedef logic [sqb_pkg::SIZE_W-1:0]         dim_t;
    typedef logic [sqb_pkg::SLOT_W-1:0]         slot_t;

    // One expected corner vertex.
    typedef struct packed {
        logic signed [sqb_pkg::COORD_W-1:0] vx;
        logic signed [sqb_pkg::COORD_W-1:0] vy;
        logic                               u;
        logic                               v;
        logic [sqb_pkg::SLOT_W-1:0]         slot_no;
        logic [sqb_pkg::COLOUR_W-1:0]       rgba;
        logic                               flush;
        logic                               tail;
    } corner_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic                                 command;
    logic signed [sqb_pkg::COORD_W-1:0]   centre_x;
    logic signed [sqb_pkg::COORD_W-1:0]   centre_y;
    logic [sqb_pkg::SIZE_W-1:0]           width;
    logic [sqb_pkg::SIZE_W-1:0]           height;
    logic                                 has_texture;
    logic [sqb_pkg::HANDLE_W-1:0]         texture_handle;
    logic [sqb_pkg::COLOUR_W-1:0]         colour;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [sqb_pkg::COORD_W-1:0]   vertex_x;
    logic signed [sqb_pkg::COORD_W-1:0]   vertex_y;
    logic                                 tex_u;
    logic                                 tex_v;
    logic [sqb_pkg::SLOT_W-1:0]           slot;
    logic [sqb_pkg::COLOUR_W-1:0]         vertex_colour;
    logic                                 flush_before;
    logic                                 last;

    // Predictor state: the textures bound in the current batch.
    logic [sqb_pkg::HANDLE_W-1:0] bound_handles [sqb_pkg::MAX_TEXTURES_DEF];
    int                           bound_count;
    corner_t                      pending_corners [$];

    // Run control and statistics.
    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_pending;
    int mismatches;
    int requests_sent;
    int sprites_sent;
    int flushes_predicted;
    int corners_checked;
    int intake_stall_cycles;
    int cycle_count;

    sprite_quad_batcher #(
        .MAX_TEXTURES(sqb_pkg::MAX_TEXTURES_DEF)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .centre_x       (centre_x),
        .centre_y       (centre_y),
        .width          (width),
        .height         (height),
        .has_texture    (has_texture),
        .texture_handle (texture_handle),
        .colour         (colour),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .slot           (slot),
        .vertex_colour  (vertex_colour),
        .flush_before   (flush_before),
        .last           (last)
    );

    always #10 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Clamp a wide sum to the signed coordinate range.
    function automatic coord_t clamp_coord(input int sum);
        if (sum > 32767)
            return 16'sh7FFF;
        if (sum < -32768)
            return 16'sh8000;
        return sum[sqb_pkg::COORD_W-1:0];
    endfunction

    // Expand the request on the input ports into expected corners.
    task automatic expand_sprite();
        slot_t   slot_no;
        bit      hit;
        bit      flushed;
        int      half_w;
        int      half_h;
        corner_t c;
        if (command == sqb_pkg::CMD_BEGIN)
        begin
            bound_count = 0;
            return;
        end
        slot_no = '0;
        hit     = 1'b0;
        flushed = 1'b0;
        if (has_texture)
        begin
            // The lowest matching entry wins.
            for (int i = 0; i < bound_count; i++)
            begin
                if (!hit && bound_handles[i] == texture_handle)
                begin
                    hit     = 1'b1;
                    slot_no = slot_t'(i + 1);
                end
            end
            // A miss on a full table clears it and flags a flush.
            if (!hit)
            begin
                if (bound_count >= sqb_pkg::MAX_TEXTURES_DEF)
                begin
                    bound_count = 0;
                    flushed     = 1'b1;
                    flushes_predicted++;
                end
                bound_handles[bound_count] = texture_handle;
                bound_count++;
                slot_no = slot_t'(bound_count);
            end
        end
        half_w = int'(width) >> 1;
        half_h = int'(height) >> 1;
        for (int k = 0; k < sqb_pkg::CORNERS; k++)
        begin
            c.vx      = clamp_coord(int'(centre_x) +
                                    (sqb_pkg::CORNER_XNEG[k] ? -half_w : half_w));
            c.vy      = clamp_coord(int'(centre_y) +
                                    (sqb_pkg::CORNER_YNEG[k] ? -half_h : half_h));
            c.u       = sqb_pkg::CORNER_U[k];
            c.v       = sqb_pkg::CORNER_V[k];
            c.slot_no = slot_no;
            c.rgba    = colour;
            c.flush   = (k == 0) && flushed;
            c.tail    = (k == sqb_pkg::CORNERS - 1);
            pending_corners.insert(pending_corners.size(), c);
        end
    endtask

    // Compare one accepted corner with the oldest expectation.
    task automatic check_corner();
        corner_t c;
        if (pending_corners.size() == 0)
        begin
            $error("Corner arrived with no sprite outstanding.");
            mismatches++;
            return;
        end
        c = pending_corners.pop_front();
        corners_checked++;
        if (vertex_x !== c.vx)
        begin
            $error("vertex_x: expected %0d, got %0d", c.vx, vertex_x);
            mismatches++;
        end
        if (vertex_y !== c.vy)
        begin
            $error("vertex_y: expected %0d, got %0d", c.vy, vertex_y);
            mismatches++;
        end
        if (tex_u !== c.u)
        begin
            $error("tex_u: expected %0d, got %0d", c.u, tex_u);
            mismatches++;
        end
        if (tex_v !== c.v)
        begin
            $error("tex_v: expected %0d, got %0d", c.v, tex_v);
            mismatches++;
        end
        if (slot !== c.slot_no)
        begin
            $error("slot: expected %0d, got %0d", c.slot_no, slot);
            mismatches++;
        end
        if (vertex_colour !== c.rgba)
        begin
            $error("vertex_colour: expected %h, got %h", c.rgba, vertex_colour);
            mismatches++;
        end
        if (flush_before !== c.flush)
        begin
            $error("flush_before: expected %0d, got %0d", c.flush, flush_before);
            mismatches++;
        end
        if (last !== c.tail)
        begin
            $error("last: expected %0d, got %0d", c.tail, last);
            mismatches++;
        end
    endtask

    // Predict on accepted requests, then check accepted corners.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                intake_stall_cycles++;
            if (in_valid && !in_stall)
                expand_sprite();
            if (out_valid && !out_stall)
                check_corner();
        end
    end

    // Output side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one request and return at the edge where it is accepted.
    task automatic send_request(
        input logic                               cmd,
        input logic signed [sqb_pkg::COORD_W-1:0] cx,
        input logic signed [sqb_pkg::COORD_W-1:0] cy,
        input logic [sqb_pkg::SIZE_W-1:0]         w,
        input logic [sqb_pkg::SIZE_W-1:0]         h,
        input logic                               textured,
        input logic [sqb_pkg::HANDLE_W-1:0]       handle,
        input logic [sqb_pkg::COLOUR_W-1:0]       rgba
    );
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        centre_x       <= cx;
        centre_y       <= cy;
        width          <= w;
        height         <= h;
        has_texture    <= textured;
        texture_handle <= handle;
        colour         <= rgba;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        if (cmd == sqb_pkg::CMD_SUBMIT)
            sprites_sent++;
    endtask

    // Begin a frame; the other fields carry random junk.
    task automatic begin_frame();
        send_request(sqb_pkg::CMD_BEGIN, coord_t'($urandom), coord_t'($urandom),
                     dim_t'($urandom), dim_t'($urandom), $urandom_range(0, 1) == 1,
                     $urandom, $urandom);
    endtask

    // Coordinates biased toward both ends of the range and toward zero.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0:       return coord_t'($urandom_range(32467, 32767));
            1:       return coord_t'($urandom_range(32768, 33068));
            2:       return coord_t'($urandom_range(0, 400) - 200);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic dim_t rand_size();
        case ($urandom_range(0, 3))
            0:       return dim_t'($urandom_range(0, 64));
            1:       return dim_t'($urandom_range(32703, 32767));
            default: return dim_t'($urandom);
        endcase
    endfunction

    // Sprite with a random position, size and colour.
    task automatic submit_random(input logic textured,
                                 input logic [sqb_pkg::HANDLE_W-1:0] handle);
        send_request(sqb_pkg::CMD_SUBMIT, rand_coord(), rand_coord(), rand_size(),
                     rand_size(), textured, handle, $urandom);
    endtask

    // Hold the input idle until every expected corner has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_corners.size() != 0)
            @(posedge clk);
    endtask

    // Extremes of every field, saturation, slot hits and misses, begin clears.
    task automatic test_directed();
        begin_frame();
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd0, 16'sd0, 15'd0, 15'd0, 1'b0,
                     32'hFFFF_FFFF, 32'h0);
        send_request(sqb_pkg::CMD_SUBMIT, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF, 1'b0,
                     32'h0, 32'hFFFF_FFFF);
        send_request(sqb_pkg::CMD_SUBMIT, 16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF, 1'b0,
                     32'hA5A5_5A5A, 32'h1234_5678);
        // Odd sizes lose their lowest fraction bit when halved.
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd100, -16'sd100, 15'd1, 15'd3, 1'b0, 32'h0,
                     32'h8000_0001);
        // Handle zero is an ordinary handle.
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd16, 16'sd32, 15'd48, 15'd64, 1'b1, 32'h0,
                     32'hDEAD_BEEF);
        send_request(sqb_pkg::CMD_SUBMIT, -16'sd16, 16'sd32, 15'd50, 15'd2, 1'b1,
                     32'hFFFF_FFFF, 32'h0F0F_0F0F);
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd5, -16'sd5, 15'd7, 15'd9, 1'b1, 32'h0,
                     32'hF0F0_F0F0);
        // An untextured sprite leaves the table alone whatever its handle.
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd1, 16'sd1, 15'd2, 15'd2, 1'b0, 32'h1234_5678,
                     32'h5555_5555);
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd2, 16'sd2, 15'd4, 15'd4, 1'b1, 32'h1234_5678,
                     32'hAAAA_AAAA);
        begin_frame();
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd0, 16'sd0, 15'd10, 15'd10, 1'b1,
                     32'hFFFF_FFFF, 32'h0000_FFFF);
        begin_frame();
        begin_frame();
        // Sums that overflow by only a few counts.
        send_request(sqb_pkg::CMD_SUBMIT, 16'sd32760, -16'sd32760, 15'd20, 15'd20, 1'b1,
                     32'h0, 32'hFFFF_0000);
        send_request(sqb_pkg::CMD_SUBMIT, 16'sh8000, 16'sh7FFF, 15'd0, 15'd1, 1'b1, 32'h0,
                     32'h0);
    endtask

    // Fill the table, hit some entries, then overflow it.
    task automatic test_table_overflow();
        logic [sqb_pkg::HANDLE_W-1:0] handles [$];
        logic [sqb_pkg::HANDLE_W-1:0] h;
        bit                           dup;
        begin_frame();
        while (handles.size() < sqb_pkg::MAX_TEXTURES_DEF + 1)
        begin
            h   = $urandom;
            dup = 1'b0;
            foreach (handles[i])
                if (handles[i] == h)
                    dup = 1'b1;
            if (!dup)
                handles.insert(handles.size(), h);
        end
        for (int i = 0; i < sqb_pkg::MAX_TEXTURES_DEF; i++)
            submit_random(1'b1, handles[i]);
        submit_random(1'b1, handles[3]);
        submit_random(1'b1, handles[sqb_pkg::MAX_TEXTURES_DEF - 1]);
        submit_random(1'b1, handles[sqb_pkg::MAX_TEXTURES_DEF]);
        submit_random(1'b1, handles[0]);
        submit_random(1'b1, handles[sqb_pkg::MAX_TEXTURES_DEF]);
    endtask

    // Long output hold-off while the sender keeps offering sprites.
    task automatic test_backpressure();
        tx_idle_en   = 1'b0;
        hold_pending = 1'b1;
        for (int i = 0; i < 12; i++)
            submit_random($urandom_range(0, 1) == 1, $urandom_range(0, 5));
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    // Frames of sprites drawing handles from a pool, with some noise.
    task automatic test_random_frames(input int n_requests);
        logic [sqb_pkg::HANDLE_W-1:0] pool [$];
        int                           start;
        int                           n_sprites;
        start = requests_sent;
        while (requests_sent - start < n_requests)
        begin
            if ($urandom_range(0, 7) != 0)
                begin_frame();
            pool.delete();
            repeat ($urandom_range(1, 24))
                pool.insert(pool.size(),
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom);
            n_sprites = $urandom_range(1, 30);
            for (int i = 0; i < n_sprites; i++)
            begin
                if ($urandom_range(0, 32) == 0)
                    begin_frame();
                else if ($urandom_range(0, 9) == 0)
                    submit_random($urandom_range(0, 6) != 0, $urandom);
                else
                    submit_random($urandom_range(0, 6) != 0,
                                  pool[$urandom_range(0, pool.size() - 1)]);
            end
        end
    endtask

    // Back-to-back sprites with no idling on either side.
    task automatic test_streaming(input int n_sprites);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        begin_frame();
        for (int i = 0; i < n_sprites; i++)
            submit_random($urandom_range(0, 4) != 0, $urandom_range(0, 19));
    endtask

    // Test sequence.
    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        command        <= sqb_pkg::CMD_BEGIN;
        centre_x       <= '0;
        centre_y       <= '0;
        width          <= '0;
        height         <= '0;
        has_texture    <= 1'b0;
        texture_handle <= '0;
        colour         <= '0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_pending = 1'b0;
        bound_count  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_overflow();
        test_backpressure();
        test_random_frames(170);
        test_streaming(40);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests (%0d sprites), checked %0d corners, %0d table flushes.",
                 requests_sent, sprites_sent, corners_checked, flushes_predicted);
        $display("Input was held off for %0d cycles; %0d mismatches.",
                 intake_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/sqb_pkg.sv
rtl/sqb_front.sv
rtl/sqb_queue.sv
rtl/sqb_back.sv
rtl/sprite_quad_batcher.sv
rtl/sqb_checker.sv
tb/tb_sprite_quad_batcher.sv
